### rtl/cibm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cibm_pkg;

	localparam int NUM_IDS      = 32768;
	localparam int WORD_BITS    = 32;
	localparam int RESERVED_IDS = 1;
	localparam int Q_DEPTH      = 2;

	localparam int MAP_WORDS  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int ID_W       = 15;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WORD_IDX_W = $clog2(MAP_WORDS);
	localparam int COUNT_W    = $clog2(NUM_IDS + 1);
	localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
	localparam int LAST_BITS  = NUM_IDS - (MAP_WORDS - 1) * WORD_BITS;

	localparam logic [WORD_BITS-1:0]  WORD_ALL       = '1;
	localparam logic [WORD_BITS-1:0]  LAST_WORD_MASK = WORD_ALL >> (WORD_BITS - LAST_BITS);
	localparam logic [WORD_IDX_W-1:0] LAST_WORD      = WORD_IDX_W'(MAP_WORDS - 1);
	localparam logic [ID_W-1:0]       LAST_ID        = ID_W'(NUM_IDS - 1);
	localparam logic [ID_W-1:0]       HINT_RESET     = ID_W'(RESERVED_IDS % NUM_IDS);
	localparam logic [COUNT_W-1:0]    COUNT_RESET    = COUNT_W'(RESERVED_IDS);
	localparam logic [COUNT_W-1:0]    COUNT_FULL     = COUNT_W'(NUM_IDS);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FULL      = 2'd1,
		ST_FREED     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_FREE,
		S_SCAN
	} eng_state_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] id;
	} cmd_t;

	function automatic logic [WORD_BITS-1:0] reserved_word(input logic [WORD_IDX_W-1:0] row);
		logic [WORD_BITS-1:0] w;
		w = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			w[b] = ((int'(row) * WORD_BITS + b) < RESERVED_IDS);
		end
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/cibm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cibm_req_if import cibm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            cmd;
	logic [ID_W-1:0] free_id;

	modport source (output valid, output cmd, output free_id, input ready);
	modport sink (input valid, input cmd, input free_id, output ready);
endinterface

`default_nettype wire

### rtl/cibm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cibm_rsp_if import cibm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] alloc_id;
	logic [1:0]      status;

	modport source (output valid, output alloc_id, output status, input ready);
	modport sink (input valid, input alloc_id, input status, output ready);
endinterface

`default_nettype wire

### rtl/cibm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cibm_front import cibm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cibm_req_if.sink   req,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic take;

	assign req.ready = !valid_s1 || cmd_ready;
	assign take      = req.valid && req.ready;

	always_comb begin
		cmd_d.op = req.cmd ? OP_FREE : OP_ALLOC;
		cmd_d.id = req.cmd ? req.free_id : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

### rtl/cibm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cibm_fifo import cibm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t               slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               push;
	logic               pop;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### rtl/cibm_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module cibm_engine import cibm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cq_valid,
	output logic       cq_ready,
	input  cmd_t       cq_cmd,
	cibm_rsp_if.source rsp
);

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

	eng_state_t            state_q, state_d;
	logic [WORD_IDX_W-1:0] clr_idx_q, clr_idx_d;
	logic [ID_W-1:0]       hint_q, hint_d;
	logic [COUNT_W-1:0]    count_q, count_d;
	logic                  first_q, first_d;
	logic                  out_valid_q, out_valid_d;
	logic [WORD_IDX_W-1:0] cur_word_q, cur_word_d;
	logic [WORD_IDX_W-1:0] scan_addr_q, scan_addr_d;
	logic [ID_W-1:0]       id_q, id_d;
	logic [ID_W-1:0]       out_id_q, out_id_d;
	status_t               out_status_q, out_status_d;
	logic [WORD_BITS-1:0]  rd_data_q;

	logic                  mem_we;
	logic [WORD_IDX_W-1:0] mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;
	logic                  mem_re;
	logic [WORD_IDX_W-1:0] mem_raddr;

	logic                  slot_free;
	logic [WORD_IDX_W-1:0] hint_word;
	logic [WORD_BITS-1:0]  scan_mask;
	logic [WORD_BITS-1:0]  avail;
	logic                  found;
	logic [BIT_W-1:0]      found_bit;
	logic [ID_W-1:0]       found_id;
	logic                  free_hit;

	function automatic logic [WORD_IDX_W-1:0] word_of(input logic [ID_W-1:0] id);
		return WORD_IDX_W'(id >> BIT_W);
	endfunction

	function automatic logic [WORD_IDX_W-1:0] next_word(input logic [WORD_IDX_W-1:0] w);
		return (w == LAST_WORD) ? '0 : w + 1'b1;
	endfunction

	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	assign slot_free = !out_valid_q || rsp.ready;
	assign hint_word = word_of(hint_q);

	always_comb begin
		scan_mask = first_q ? (WORD_ALL << hint_q[BIT_W-1:0]) : WORD_ALL;
		if (cur_word_q == LAST_WORD) begin
			scan_mask = scan_mask & LAST_WORD_MASK;
		end
		avail     = ~rd_data_q & scan_mask;
		found     = (avail != '0);
		found_bit = first_set(avail);
		found_id  = ID_W'({cur_word_q, found_bit});
		free_hit  = (COUNT_W'(id_q) < COUNT_FULL) && rd_data_q[id_q[BIT_W-1:0]];
	end

	always_comb begin
		state_d      = state_q;
		clr_idx_d    = clr_idx_q;
		hint_d       = hint_q;
		count_d      = count_q;
		first_d      = first_q;
		cur_word_d   = cur_word_q;
		scan_addr_d  = scan_addr_q;
		id_d         = id_q;
		out_valid_d  = out_valid_q && !rsp.ready;
		out_id_d     = out_id_q;
		out_status_d = out_status_q;
		mem_we       = 1'b0;
		mem_waddr    = cur_word_q;
		mem_wdata    = rd_data_q;
		mem_re       = 1'b0;
		mem_raddr    = scan_addr_q;
		cq_ready     = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = reserved_word(clr_idx_q);
				if (clr_idx_q == LAST_WORD) begin
					state_d = S_IDLE;
				end else begin
					clr_idx_d = clr_idx_q + 1'b1;
				end
			end
			S_IDLE: begin
				cq_ready = slot_free;
				if (cq_valid && slot_free) begin
					if (cq_cmd.op == OP_FREE) begin
						id_d      = cq_cmd.id;
						mem_re    = 1'b1;
						mem_raddr = word_of(cq_cmd.id);
						state_d   = S_FREE;
					end else if (count_q == COUNT_FULL) begin
						out_valid_d  = 1'b1;
						out_id_d     = '0;
						out_status_d = ST_FULL;
					end else begin
						mem_re      = 1'b1;
						mem_raddr   = hint_word;
						cur_word_d  = hint_word;
						scan_addr_d = next_word(hint_word);
						first_d     = 1'b1;
						state_d     = S_SCAN;
					end
				end
			end
			S_FREE: begin
				mem_waddr = word_of(id_q);
				mem_wdata = rd_data_q & ~(WORD_BITS'(1) << id_q[BIT_W-1:0]);
				if (free_hit) begin
					mem_we  = 1'b1;
					count_d = count_q - 1'b1;
				end
				out_valid_d  = 1'b1;
				out_id_d     = '0;
				out_status_d = ST_FREED;
				state_d      = S_IDLE;
			end
			S_SCAN: begin
				if (found) begin
					mem_we       = 1'b1;
					mem_waddr    = cur_word_q;
					mem_wdata    = rd_data_q | (WORD_BITS'(1) << found_bit);
					count_d      = count_q + 1'b1;
					hint_d       = (found_id == LAST_ID) ? '0 : found_id + 1'b1;
					out_valid_d  = 1'b1;
					out_id_d     = found_id;
					out_status_d = ST_ALLOCATED;
					state_d      = S_IDLE;
				end else begin
					mem_re      = 1'b1;
					mem_raddr   = scan_addr_q;
					cur_word_d  = scan_addr_q;
					scan_addr_d = next_word(scan_addr_q);
					first_d     = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			hint_q      <= HINT_RESET;
			count_q     <= COUNT_RESET;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_idx_q   <= clr_idx_d;
			hint_q      <= hint_d;
			count_q     <= count_d;
			first_q     <= first_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_word_q   <= cur_word_d;
		scan_addr_q  <= scan_addr_d;
		id_q         <= id_d;
		out_id_q     <= out_id_d;
		out_status_q <= out_status_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= map_mem[mem_raddr];
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.alloc_id = out_id_q;
	assign rsp.status   = out_status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("used count above map size");

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !cq_ready)
		else $error("command taken during clearing pass");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> (count_q == COUNT_FULL))
		else $error("full status with free entries left");

	a_alloc_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && found) |=>
		(out_valid_q && out_status_q == ST_ALLOCATED
		&& count_q == COUNT_W'($past(count_q) + 1'b1)))
		else $error("allocation did not post result and count");

	a_slot_empty_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE || state_q == S_SCAN) |-> !out_valid_q)
		else $error("result pending while a command is in flight");
`endif

endmodule

`default_nettype wire

### rtl/context_id_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Hands out and takes back 15-bit context identifiers from a 32768-entry bitmap held in a
// 1024 x 32 memory with one write port and one read port. After reset the block runs a
// clearing pass (one word per cycle, context 0 left reserved) and serves no request until it
// ends; up to three requests are taken and held meanwhile. Requests pass a front register and
// a two-word queue, so up to three are taken while a response is still waiting. An allocate
// reads the bitmap word holding the search hint and then further words, one word per cycle
// through the memory read port, until it finds a free entry; when every entry is taken it
// answers full without reading the bitmap. Status: 0 allocated, 1 full, 2 freed; alloc_id is
// zero except for an allocation.
module context_id_bitmap_allocator import cibm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cibm_req_if.sink   req,
	cibm_rsp_if.source rsp
);

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic cq_valid;
	logic cq_ready;
	cmd_t cq_cmd;

	cibm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	cibm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_cmd   (fr_cmd),
		.pop_valid  (cq_valid),
		.pop_ready  (cq_ready),
		.pop_cmd    (cq_cmd)
	);

	cibm_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (cq_valid),
		.cq_ready (cq_ready),
		.cq_cmd   (cq_cmd),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
